### rtl/core/imt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imt_pkg
// Shared types and constants of the in-place matrix transpose store: beat
// payloads, request and status codes, and the sequencer state encoding.
// ----------------------------------------------------------------------------
package imt_pkg;

    // Default store depth in elements
    localparam int MAX_ELEMENTS_DEF = 128;

    // Field widths
    localparam int WORD_W = 64;
    localparam int IDX_W  = 7;
    localparam int DIM_W  = 7;
    localparam int PROD_W = 2 * DIM_W;

    // Request codes
    localparam logic [1:0] REQ_WRITE     = 2'd0;
    localparam logic [1:0] REQ_READ      = 2'd1;
    localparam logic [1:0] REQ_TRANSPOSE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_RANGE      = 2'd1;
    localparam logic [1:0] ST_ZERO_SHAPE = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  elem_index;
        logic [WORD_W-1:0] elem_value;
        logic [DIM_W-1:0]  mat_rows;
        logic [DIM_W-1:0]  mat_cols;
    } imt_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [1:0]        status;
        logic [DIM_W-1:0]  new_rows;
        logic [DIM_W-1:0]  new_cols;
    } imt_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_CHK_START,
        ST_CHK_DIV,
        ST_CHK_MUL,
        ST_CHK_EVAL,
        ST_NEXT,
        ST_MV_LOAD,
        ST_MV_HOLD,
        ST_MV_DIV,
        ST_MV_MUL,
        ST_MV_READ,
        ST_MV_WRITE,
        ST_TP_DONE
    } imt_state_t;

endpackage
`default_nettype wire

### rtl/core/inplace_matrix_transpose.sv
`default_nettype none
// Write: result beat in the cycle after accept. Read: the word passes through the
// registered read port and the ST_RD_WAIT state before its beat. Range, shape
// and unknown-request errors: beat in the cycle after accept. Transpose:
// sequential, walking each permutation cycle and then moving its elements;
// the bit-serial divider sets the step. One item at a time. Reset clears control
// state only; the store holds undefined words until written (no clearing pass).
// ----------------------------------------------------------------------------
// inplace_matrix_transpose
// Element store with write, read and in-place transpose of a row-major
// matrix by permutation cycle following from each cycle's smallest position.
// ----------------------------------------------------------------------------
module inplace_matrix_transpose #(
    parameter int MAX_ELEMENTS = imt_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire imt_pkg::imt_req_t req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output imt_pkg::imt_rsp_t      rsp_data
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int PW = imt_pkg::PROD_W;
    localparam int DW = imt_pkg::DIM_W;

    // Element store
    logic [imt_pkg::WORD_W-1:0] store_mem [MAX_ELEMENTS];
    logic [imt_pkg::WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [imt_pkg::WORD_W-1:0] wr_data;

    imt_pkg::imt_state_t        state_reg, state_next;
    logic [CW-1:0]              start_reg, start_next;
    logic [CW-1:0]              total_reg, total_next;
    logic                       first_reg, first_next;
    logic [DW-1:0]              rows_reg, rows_next;
    logic [DW-1:0]              cols_reg, cols_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              dest_reg, dest_next;
    logic [imt_pkg::WORD_W-1:0] held_reg, held_next;
    logic                       out_valid_reg, out_valid_next;
    imt_pkg::imt_rsp_t          out_data_reg, out_data_next;

    // Divider hookup
    logic                       div_go;
    logic [AW-1:0]              div_arg;
    logic                       div_done;
    logic [AW-1:0]              div_quot;
    logic [DW-1:0]              div_rem;

    // Request decode
    logic                       out_free;
    logic                       accept;
    logic [DW-1:0]              cols_eff;
    logic [PW-1:0]              shape_prod;
    logic                       idx_ok;
    logic [PW-1:0]              dest_full;
    logic [CW-1:0]              start_inc;
    logic                       at_start;
    imt_pkg::imt_rsp_t          rsp_blank;

    imt_div #(
        .DIVIDEND_W (AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (div_arg),
        .divisor  (rows_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign out_free   = !out_valid_reg || !rsp_stall;
    assign req_stall  = !((state_reg == imt_pkg::ST_IDLE) && out_free);
    assign accept     = req_valid && !req_stall;

    assign cols_eff   = (req_data.mat_cols == '0) ? req_data.mat_rows : req_data.mat_cols;
    assign shape_prod = PW'(req_data.mat_rows) * PW'(cols_eff);
    assign idx_ok     = (32'(req_data.elem_index) < 32'(MAX_ELEMENTS));

    // Destination of a position: remainder times columns plus quotient
    assign dest_full  = PW'(div_rem) * PW'(cols_reg) + PW'(div_quot);
    assign start_inc  = start_reg + 1'b1;
    assign at_start   = (CW'(dest_reg) == start_reg);

    always_comb
    begin
        rsp_blank            = '0;
        rsp_blank.read_value = '0;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        total_next     = total_reg;
        first_next     = first_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        pos_next       = pos_reg;
        dest_next      = dest_reg;
        held_next      = held_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        rd_addr        = pos_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = req_data.elem_value;
        div_go         = 1'b0;
        div_arg        = pos_reg;

        case (state_reg)
            imt_pkg::ST_IDLE:
            begin
                rd_addr = AW'(req_data.elem_index);
                wr_addr = AW'(req_data.elem_index);
                if (accept)
                begin
                    out_data_next = rsp_blank;
                    case (req_data.req_type)
                        imt_pkg::REQ_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            if (idx_ok)
                            begin
                                wr_en = 1'b1;
                            end
                            else
                            begin
                                out_data_next.status = imt_pkg::ST_RANGE;
                            end
                        end
                        imt_pkg::REQ_READ:
                        begin
                            if (idx_ok)
                            begin
                                pos_next   = AW'(req_data.elem_index);
                                state_next = imt_pkg::ST_RD_WAIT;
                            end
                            else
                            begin
                                out_valid_next       = 1'b1;
                                out_data_next.status = imt_pkg::ST_RANGE;
                            end
                        end
                        imt_pkg::REQ_TRANSPOSE:
                        begin
                            if (shape_prod > PW'(MAX_ELEMENTS))
                            begin
                                out_valid_next       = 1'b1;
                                out_data_next.status = imt_pkg::ST_RANGE;
                            end
                            else if (shape_prod == '0)
                            begin
                                out_valid_next       = 1'b1;
                                out_data_next.status = imt_pkg::ST_ZERO_SHAPE;
                            end
                            else
                            begin
                                rows_next  = req_data.mat_rows;
                                cols_next  = cols_eff;
                                total_next = CW'(shape_prod);
                                start_next = '0;
                                state_next = imt_pkg::ST_CHK_START;
                            end
                        end
                        default:
                        begin
                            out_valid_next       = 1'b1;
                            out_data_next.status = imt_pkg::ST_RANGE;
                        end
                    endcase
                end
            end

            // Hand back the read word once the beat slot is free
            imt_pkg::ST_RD_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next            = rsp_blank;
                    out_data_next.read_value = rd_data_reg;
                    state_next               = imt_pkg::ST_IDLE;
                end
            end

            // Walk the cycle from the current start to see who leads it
            imt_pkg::ST_CHK_START:
            begin
                div_go     = 1'b1;
                div_arg    = start_reg[AW-1:0];
                first_next = 1'b1;
                state_next = imt_pkg::ST_CHK_DIV;
            end

            imt_pkg::ST_CHK_DIV:
            begin
                if (div_done)
                begin
                    state_next = imt_pkg::ST_CHK_MUL;
                end
            end

            imt_pkg::ST_CHK_MUL:
            begin
                dest_next  = AW'(dest_full);
                state_next = imt_pkg::ST_CHK_EVAL;
            end

            imt_pkg::ST_CHK_EVAL:
            begin
                if (CW'(dest_reg) > start_reg)
                begin
                    div_go     = 1'b1;
                    div_arg    = dest_reg;
                    first_next = 1'b0;
                    state_next = imt_pkg::ST_CHK_DIV;
                end
                else if (!at_start || first_reg)
                begin
                    state_next = imt_pkg::ST_NEXT;
                end
                else
                begin
                    state_next = imt_pkg::ST_MV_LOAD;
                end
            end

            // Advance to the next start position
            imt_pkg::ST_NEXT:
            begin
                start_next = start_inc;
                if (start_inc == total_reg)
                begin
                    state_next = imt_pkg::ST_TP_DONE;
                end
                else
                begin
                    state_next = imt_pkg::ST_CHK_START;
                end
            end

            // Set the leading word aside
            imt_pkg::ST_MV_LOAD:
            begin
                rd_addr    = start_reg[AW-1:0];
                pos_next   = start_reg[AW-1:0];
                state_next = imt_pkg::ST_MV_HOLD;
            end

            imt_pkg::ST_MV_HOLD:
            begin
                held_next  = rd_data_reg;
                div_go     = 1'b1;
                div_arg    = pos_reg;
                state_next = imt_pkg::ST_MV_DIV;
            end

            imt_pkg::ST_MV_DIV:
            begin
                if (div_done)
                begin
                    state_next = imt_pkg::ST_MV_MUL;
                end
            end

            imt_pkg::ST_MV_MUL:
            begin
                dest_next  = AW'(dest_full);
                state_next = imt_pkg::ST_MV_READ;
            end

            imt_pkg::ST_MV_READ:
            begin
                rd_addr    = dest_reg;
                state_next = imt_pkg::ST_MV_WRITE;
            end

            // Pull the source word in, or drop the held word to close the cycle
            imt_pkg::ST_MV_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = at_start ? held_reg : rd_data_reg;
                if (at_start)
                begin
                    state_next = imt_pkg::ST_NEXT;
                end
                else
                begin
                    pos_next   = dest_reg;
                    div_go     = 1'b1;
                    div_arg    = dest_reg;
                    state_next = imt_pkg::ST_MV_DIV;
                end
            end

            imt_pkg::ST_TP_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next          = rsp_blank;
                    out_data_next.new_rows = cols_reg;
                    out_data_next.new_cols = rows_reg;
                    state_next             = imt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = imt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            total_reg     <= '0;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            total_reg     <= total_next;
            first_reg     <= first_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rows_reg     <= rows_next;
        cols_reg     <= cols_next;
        pos_reg      <= pos_next;
        dest_reg     <= dest_next;
        held_reg     <= held_next;
        out_data_reg <= out_data_next;
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule
`default_nettype wire

### rtl/core/imt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imt_div
// Restoring radix-2 divider: splits an element position into quotient and
// remainder by the row count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imt_div #(
    parameter int DIVIDEND_W = 7
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [DIVIDEND_W-1:0]        dividend,
    input  wire logic [imt_pkg::DIM_W-1:0]    divisor,
    output logic                              done,
    output logic [DIVIDEND_W-1:0]             quot,
    output logic [imt_pkg::DIM_W-1:0]         rem
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0]         work_reg, work_next;
    logic [imt_pkg::DIM_W-1:0]     rem_reg, rem_next;

    logic [imt_pkg::DIM_W:0]       trial;
    logic                          ge;

    // Trial subtract of one shifted-in dividend bit
    assign trial = {rem_reg, work_reg[DIVIDEND_W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    // Load, step and finish
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            work_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DIVIDEND_W-2:0], ge};
            rem_next  = ge ? imt_pkg::DIM_W'(trial - {1'b0, divisor})
                           : imt_pkg::DIM_W'(trial);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = work_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

### tb/sv/inplace_matrix_transpose_tb.sv
// ----------------------------------------------------------------------------
// inplace_matrix_transpose_tb
// Self-checking bench for the in-place transpose store. A scoreboard keeps
// its own copy of the element words and predicts one response per accepted
// request beat. The bench drives directed corner cases first and then random
// writes, read-backs and transposes, under several idling and stall mixes.
// ----------------------------------------------------------------------------
module inplace_matrix_transpose_tb;

    localparam int STORE_DEPTH = imt_pkg::MAX_ELEMENTS_DEF;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int RANDOM_PER_PHASE = 375;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 50;

    // Predicts responses from a private copy of the store
    class element_store_model;
        logic [imt_pkg::WORD_W-1:0] words [STORE_DEPTH];
        bit                         known [STORE_DEPTH];
        imt_pkg::imt_rsp_t          expected_rsps [$];
        int                         mismatches;
        int                         rsps_checked;
        int                         reqs_by_type [4];

        function int unsigned landing_pos(int unsigned pos, int unsigned rows,
                                          int unsigned cols);
            return (pos % rows) * cols + pos / rows;
        endfunction

        // Rotate each permutation cycle from its smallest position
        function void transpose_words(int unsigned rows, int unsigned cols);
            int unsigned total;
            int unsigned pos;
            int unsigned src;
            int unsigned len;
            logic [imt_pkg::WORD_W-1:0] held_word;
            bit held_known;
            total = rows * cols;
            for (int unsigned start = 0; start < total; start++)
            begin
                pos = start;
                len = 0;
                do
                begin
                    len++;
                    pos = landing_pos(pos, rows, cols);
                end while (pos > start);
                if (pos < start || len == 1)
                    continue;
                held_word  = words[STORE_AW'(start)];
                held_known = known[STORE_AW'(start)];
                pos = start;
                do
                begin
                    src = landing_pos(pos, rows, cols);
                    if (src == start)
                    begin
                        words[STORE_AW'(pos)] = held_word;
                        known[STORE_AW'(pos)] = held_known;
                    end
                    else
                    begin
                        words[STORE_AW'(pos)] = words[STORE_AW'(src)];
                        known[STORE_AW'(pos)] = known[STORE_AW'(src)];
                    end
                    pos = src;
                end while (pos > start);
            end
        endfunction

        // Work out the response of one accepted request beat
        function void note_request(imt_pkg::imt_req_t req);
            imt_pkg::imt_rsp_t want;
            int unsigned rows;
            int unsigned cols;
            want = '0;
            rows = 32'(req.mat_rows);
            cols = 32'(req.mat_cols);
            reqs_by_type[req.req_type]++;
            case (req.req_type)
                imt_pkg::REQ_WRITE, imt_pkg::REQ_READ:
                begin
                    if (req.elem_index >= STORE_DEPTH)
                        want.status = imt_pkg::ST_RANGE;
                    else if (req.req_type == imt_pkg::REQ_WRITE)
                    begin
                        words[req.elem_index] = req.elem_value;
                        known[req.elem_index] = 1'b1;
                    end
                    else
                        want.read_value = words[req.elem_index];
                end
                imt_pkg::REQ_TRANSPOSE:
                begin
                    if (cols == 0)
                        cols = rows;
                    if (rows * cols > STORE_DEPTH)
                        want.status = imt_pkg::ST_RANGE;
                    else if (rows == 0 || cols == 0)
                        want.status = imt_pkg::ST_ZERO_SHAPE;
                    else
                    begin
                        transpose_words(rows, cols);
                        want.new_rows = cols[imt_pkg::DIM_W-1:0];
                        want.new_cols = rows[imt_pkg::DIM_W-1:0];
                    end
                end
                default:
                    want.status = imt_pkg::ST_RANGE;
            endcase
            expected_rsps.push_back(want);
        endfunction

        // Compare one response beat with the oldest expectation
        function void check_response(imt_pkg::imt_rsp_t got);
            imt_pkg::imt_rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $error("response beat with nothing outstanding: %p", got);
                mismatches++;
                return;
            end
            want = expected_rsps.pop_front();
            rsps_checked++;
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.new_rows !== want.new_rows)
            begin
                $error("new_rows: expected %0d, got %0d", want.new_rows, got.new_rows);
                mismatches++;
            end
            if (got.new_cols !== want.new_cols)
            begin
                $error("new_cols: expected %0d, got %0d", want.new_cols, got.new_cols);
                mismatches++;
            end
        endfunction

        // Find a written entry below limit, or -1 when there is none
        function int pick_known(int limit);
            int start;
            int idx;
            start = $urandom_range(limit - 1);
            for (int i = 0; i < limit; i++)
            begin
                idx = (start + i) % limit;
                if (known[STORE_AW'(idx)])
                    return idx;
            end
            return -1;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    imt_pkg::imt_req_t req_data = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    imt_pkg::imt_rsp_t rsp_data;

    element_store_model store_model;
    int  req_idle_pct = 0;
    int  rsp_stall_pct = 0;
    bit  hold_off_request = 1'b0;

    inplace_matrix_transpose #(
        .MAX_ELEMENTS(STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Stall the response side at random, or hold off for a long stretch
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // Check every accepted response beat
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            store_model.check_response(rsp_data);
    end

    function automatic imt_pkg::imt_req_t make_req(logic [1:0] kind, int idx,
                                                   logic [imt_pkg::WORD_W-1:0] value,
                                                   int rows, int cols);
        imt_pkg::imt_req_t req;
        req.req_type   = kind;
        req.elem_index = idx[imt_pkg::IDX_W-1:0];
        req.elem_value = value;
        req.mat_rows   = rows[imt_pkg::DIM_W-1:0];
        req.mat_cols   = cols[imt_pkg::DIM_W-1:0];
        return req;
    endfunction

    // Mostly writes and read-backs near the matrix origin, with transposes and rare unknown requests
    function automatic imt_pkg::imt_req_t random_request();
        imt_pkg::imt_req_t req;
        int unsigned roll;
        int pick;
        int rows;
        req.req_type   = imt_pkg::REQ_WRITE;
        req.elem_index = imt_pkg::IDX_W'($urandom);
        req.elem_value = {$urandom, $urandom};
        req.mat_rows   = imt_pkg::DIM_W'($urandom);
        req.mat_cols   = imt_pkg::DIM_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 45)
        begin
            if ($urandom_range(99) < 70)
                req.elem_index = imt_pkg::IDX_W'($urandom_range(31));
        end
        else if (roll < 82)
        begin
            pick = store_model.pick_known(($urandom_range(99) < 70) ? 32 : STORE_DEPTH);
            if (pick >= 0)
            begin
                req.req_type   = imt_pkg::REQ_READ;
                req.elem_index = pick[imt_pkg::IDX_W-1:0];
            end
        end
        else if (roll < 94)
        begin
            req.req_type = imt_pkg::REQ_TRANSPOSE;
            req.mat_rows = imt_pkg::DIM_W'($urandom_range(1, 6));
            req.mat_cols = imt_pkg::DIM_W'($urandom_range(0, 6));
        end
        else if (roll < 96)
        begin
            rows = $urandom_range(1, 16);
            req.req_type = imt_pkg::REQ_TRANSPOSE;
            req.mat_rows = rows[imt_pkg::DIM_W-1:0];
            req.mat_cols = imt_pkg::DIM_W'($urandom_range(1,
                               (rows == 1) ? 127 : STORE_DEPTH / rows));
        end
        else if (roll < 99)
        begin
            req.req_type = imt_pkg::REQ_TRANSPOSE;
            if ($urandom_range(1))
                req.mat_rows = '0;
            else
            begin
                req.mat_rows = imt_pkg::DIM_W'($urandom_range(12, 127));
                req.mat_cols = imt_pkg::DIM_W'($urandom_range(12, 127));
            end
        end
        else
            req.req_type = REQ_UNKNOWN;
        return req;
    endfunction

    // Offer one beat after a random gap and wait until it is taken
    task automatic send_request(input imt_pkg::imt_req_t req);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        store_model.note_request(req);
    endtask

    initial
    begin
        int idle_mix [4];
        int stall_mix [4];
        idle_mix  = '{0, 88, 0, 35};
        stall_mix = '{0, 0, 88, 35};
        store_model = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: field extremes, all requests, shape errors
        send_request(make_req(imt_pkg::REQ_WRITE, 0, '0, 0, 0));
        send_request(make_req(imt_pkg::REQ_WRITE, 127, '1, 127, 127));
        send_request(make_req(imt_pkg::REQ_READ, 127, '0, 0, 0));
        send_request(make_req(imt_pkg::REQ_READ, 0, '1, 127, 127));
        send_request(make_req(imt_pkg::REQ_WRITE, 1, 64'hA5A5_5A5A_0123_4567, 0, 0));
        send_request(make_req(imt_pkg::REQ_WRITE, 2, 64'h5A5A_A5A5_89AB_CDEF, 0, 0));
        send_request(make_req(imt_pkg::REQ_WRITE, 3, 64'h8000_0000_0000_0001, 0, 0));
        send_request(make_req(imt_pkg::REQ_WRITE, 4, 64'h7FFF_FFFF_FFFF_FFFE, 0, 0));
        send_request(make_req(imt_pkg::REQ_WRITE, 5, 64'hDEAD_BEEF_CAFE_F00D, 0, 0));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 2, 3));
        send_request(make_req(imt_pkg::REQ_READ, 1, '0, 0, 0));
        send_request(make_req(imt_pkg::REQ_READ, 4, '0, 0, 0));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 2, 0));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 0, 5));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 0, 0));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 1, 1));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 12, 11));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 127, '1, 127, 127));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 1, 127));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 8, 16));
        send_request(make_req(imt_pkg::REQ_TRANSPOSE, 0, '0, 64, 2));
        send_request(make_req(REQ_UNKNOWN, 0, '0, 0, 0));
        send_request(make_req(imt_pkg::REQ_READ, 0, '0, 0, 0));
        send_request(make_req(imt_pkg::REQ_READ, 127, '0, 0, 0));

        // Random traffic under each idling and stall mix
        for (int phase = 0; phase < 4; phase++)
        begin
            req_idle_pct  = idle_mix[2'(phase)];
            rsp_stall_pct = stall_mix[2'(phase)];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (phase == 0 && n == 40)
                    hold_off_request = 1'b1;
                send_request(random_request());
            end
        end
        req_valid <= 1'b0;

        // Drain, then allow late stray beats to show up
        while (store_model.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d writes, %0d reads, %0d transposes, %0d unknown requests",
                 store_model.reqs_by_type[imt_pkg::REQ_WRITE],
                 store_model.reqs_by_type[imt_pkg::REQ_READ],
                 store_model.reqs_by_type[imt_pkg::REQ_TRANSPOSE],
                 store_model.reqs_by_type[REQ_UNKNOWN]);
        $display("Checked %0d responses across four idling mixes and a long hold-off",
                 store_model.rsps_checked);
        if (store_model.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #(12 * 40_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
